[hdl/dpr_pkg.sv]
// dpr_pkg: shared types and constants for the int8 dot product requantizer
// holds the configuration struct, register indexes and the back-end state type
// no dependencies
package dpr_pkg;

   // fixed field widths
   localparam int ACT_WIDTH       = 8;
   localparam int BIAS_WIDTH      = 32;
   localparam int MULT_WIDTH      = 31;
   localparam int SHIFT_WIDTH     = 6;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 32;

   // the scaler walks the accumulator in chunks of this many bits
   localparam int CHUNK_WIDTH = 16;

   // depth of the queue between front and back, a power of two
   localparam int QUEUE_DEPTH = 2;

   // int8 bounds
   localparam logic signed [7:0] INT8_MIN = -8'sd128;
   localparam logic signed [7:0] INT8_MAX = 8'sd127;

   // configuration register indexes
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_ACT_ZP = 3'd0,
      CSR_WGT_ZP = 3'd1,
      CSR_OUT_ZP = 3'd2,
      CSR_MULT   = 3'd3,
      CSR_SHIFT  = 3'd4,
      CSR_RELU   = 3'd5
   } csr_index_type;

   // configuration register file
   typedef struct packed {
      logic signed [7:0]       act_zp;
      logic signed [7:0]       wgt_zp;
      logic signed [7:0]       out_zp;
      logic [MULT_WIDTH-1:0]   mult;
      logic [SHIFT_WIDTH-1:0]  shift;
      logic                    relu_en;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      act_zp:  8'sd0,
      wgt_zp:  8'sd0,
      out_zp:  8'sd0,
      mult:    31'h4000_0000,
      shift:   6'd30,
      relu_en: 1'b0
   };

   // back-end sequencer states
   typedef enum logic [3:0] {
      BK_IDLE = 4'b0001,
      BK_MUL  = 4'b0010,
      BK_RND  = 4'b0100,
      BK_OUT  = 4'b1000
   } back_state_type;

endpackage

[hdl/dpr_front.sv]
// dpr_front: accepts operand pairs, multiplies and accumulates them
// pushes the biased total of each finished dot product into the queue
// depends on dpr_pkg
module dpr_front #(
   parameter int ACC_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  dpr_pkg::cfg_type                    cfg,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [dpr_pkg::ACT_WIDTH-1:0] req_activation,
   input  logic signed [dpr_pkg::ACT_WIDTH-1:0] req_weight,
   input  logic signed [dpr_pkg::BIAS_WIDTH-1:0] req_bias_value,
   input  logic                                req_last_element,
   output logic                                push_valid,
   output logic [ACC_WIDTH-1:0]                push_data,
   input  logic                                queue_full
);
   import dpr_pkg::*;

   localparam int DIFF_WIDTH = ACT_WIDTH + 1;
   localparam int PROD_WIDTH = 2 * DIFF_WIDTH;

   logic                          s1_valid_ff, s1_valid_in;
   logic                          s1_last_ff;
   logic signed [PROD_WIDTH-1:0]  s1_prod_ff;
   logic signed [BIAS_WIDTH-1:0]  s1_bias_ff;
   logic [ACC_WIDTH-1:0]          acc_ff, acc_in;

   logic                          s1_block;
   logic                          accept;
   logic                          fire;
   logic signed [DIFF_WIDTH-1:0]  act_diff;
   logic signed [DIFF_WIDTH-1:0]  wgt_diff;
   logic signed [PROD_WIDTH-1:0]  prod;
   logic [ACC_WIDTH-1:0]          prod_ext;
   logic [ACC_WIDTH-1:0]          bias_term;
   logic [ACC_WIDTH-1:0]          total;

   // a finished total waits in stage one while the queue is full
   assign s1_block  = s1_valid_ff & s1_last_ff & queue_full;
   assign req_stall = s1_block;
   assign accept    = req_valid & ~req_stall;
   assign fire      = s1_valid_ff & ~s1_block;

   // zero point removal and product
   assign act_diff = {req_activation[ACT_WIDTH-1], req_activation} -
                     {cfg.act_zp[7], cfg.act_zp};
   assign wgt_diff = {req_weight[ACT_WIDTH-1], req_weight} -
                     {cfg.wgt_zp[7], cfg.wgt_zp};
   assign prod     = act_diff * wgt_diff;

   // stage one valid
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (!s1_block) begin
         s1_valid_in = accept;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // stage one payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_last_ff <= req_last_element;
         s1_prod_ff <= prod;
         s1_bias_ff <= req_bias_value;
      end
   end

   // accumulate, adding the bias on the last element
   assign prod_ext  = ACC_WIDTH'(s1_prod_ff);
   assign bias_term = s1_last_ff ? ACC_WIDTH'(s1_bias_ff) : '0;
   assign total     = acc_ff + prod_ext + bias_term;

   always_comb begin
      acc_in = acc_ff;
      if (fire) begin
         acc_in = s1_last_ff ? '0 : total;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   assign push_valid = fire & s1_last_ff;
   assign push_data  = total;

endmodule

[hdl/dpr_queue.sv]
// dpr_queue: short queue of finished accumulator totals
// decouples the accumulating front from the scaling back end
// depends on dpr_pkg
module dpr_queue #(
   parameter int WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   import dpr_pkg::*;

   localparam int PTR_WIDTH = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0]     entry_ff [QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0] count_ff, count_in;
   logic                 do_push;
   logic                 do_pop;

   assign full     = (count_ff == CNT_WIDTH'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push_valid & ~full;
   assign do_pop   = pop & ~empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[hdl/dpr_back.sv]
// dpr_back: requantizes one accumulator total at a time to int8
// chunked multiply, rounding shift, zero point, saturation, relu, output register
// depends on dpr_pkg
module dpr_back #(
   parameter int ACC_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dpr_pkg::cfg_type      cfg,
   input  logic                  queue_empty,
   input  logic [ACC_WIDTH-1:0]  queue_data,
   output logic                  queue_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic signed [7:0]     rsp_out_value,
   output logic                  rsp_saturated
);
   import dpr_pkg::*;

   localparam int NCHUNK     = (ACC_WIDTH + CHUNK_WIDTH - 1) / CHUNK_WIDTH;
   localparam int EXT_WIDTH  = NCHUNK * CHUNK_WIDTH;
   localparam int PP_WIDTH   = CHUNK_WIDTH + 1 + MULT_WIDTH + 1;
   localparam int PROD_WIDTH = EXT_WIDTH + MULT_WIDTH + 1;
   localparam int T_WIDTH    = PROD_WIDTH + 1;
   localparam int CNT_WIDTH  = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
   localparam int V_WIDTH    = 10;

   localparam logic signed [T_WIDTH-1:0] Q_HI = T_WIDTH'(255);
   localparam logic signed [T_WIDTH-1:0] Q_LO = -T_WIDTH'(256);

   back_state_type               state_ff, state_in;
   logic [EXT_WIDTH-1:0]         acc_ff, acc_in;
   logic [CNT_WIDTH-1:0]         chunk_ff, chunk_in;
   logic signed [PROD_WIDTH-1:0] prod_ff, prod_in;
   logic signed [T_WIDTH-1:0]    q_ff, q_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [7:0]            rsp_value_ff, rsp_value_in;
   logic                         rsp_sat_ff, rsp_sat_in;

   logic                         top_chunk;
   logic [CHUNK_WIDTH-1:0]       chunk;
   logic signed [PP_WIDTH-1:0]   pp;
   logic signed [T_WIDTH-1:0]    rnd;
   logic signed [T_WIDTH-1:0]    t_sum;
   logic                         out_free;
   logic signed [V_WIDTH-1:0]    v_small;
   logic                         in_range;
   logic                         sat_hi;
   logic                         sat_lo;
   logic signed [7:0]            clamped;

   // partial product: top chunk signed, the rest unsigned
   assign top_chunk = (chunk_ff == '0);
   assign chunk     = acc_ff[EXT_WIDTH-1 -: CHUNK_WIDTH];
   assign pp        = $signed({top_chunk & chunk[CHUNK_WIDTH-1], chunk}) *
                      $signed({1'b0, cfg.mult});

   // round half up, then arithmetic shift
   assign rnd   = (cfg.shift == '0) ? '0 : (T_WIDTH'(1) << (cfg.shift - 1'b1));
   assign t_sum = T_WIDTH'(prod_ff) + rnd;

   // zero point and int8 saturation
   assign in_range = (q_ff <= Q_HI) && (q_ff >= Q_LO);
   assign v_small  = q_ff[V_WIDTH-1:0] + V_WIDTH'(cfg.out_zp);
   assign sat_hi   = (q_ff > Q_HI) || (in_range && (v_small > V_WIDTH'(INT8_MAX)));
   assign sat_lo   = (q_ff < Q_LO) || (in_range && (v_small < V_WIDTH'(INT8_MIN)));
   assign clamped  = sat_hi ? INT8_MAX : (sat_lo ? INT8_MIN : v_small[7:0]);

   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign queue_pop = (state_ff == BK_IDLE) & ~queue_empty;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      chunk_in     = chunk_ff;
      prod_in      = prod_ff;
      q_in         = q_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_value_in = rsp_value_ff;
      rsp_sat_in   = rsp_sat_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (!queue_empty) begin
               acc_in   = EXT_WIDTH'($signed(queue_data));
               chunk_in = '0;
               prod_in  = '0;
               state_in = BK_MUL;
            end
         end
         BK_MUL: begin
            prod_in  = (prod_ff <<< CHUNK_WIDTH) + PROD_WIDTH'(pp);
            acc_in   = acc_ff << CHUNK_WIDTH;
            chunk_in = chunk_ff + 1'b1;
            if (chunk_ff == CNT_WIDTH'(NCHUNK - 1)) begin
               state_in = BK_RND;
            end
         end
         BK_RND: begin
            q_in     = t_sum >>> cfg.shift;
            state_in = BK_OUT;
         end
         BK_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (cfg.relu_en && (clamped < cfg.out_zp)) begin
                  rsp_value_in = cfg.out_zp;
                  rsp_sat_in   = 1'b0;
               end else begin
                  rsp_value_in = clamped;
                  rsp_sat_in   = sat_hi | sat_lo;
               end
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      acc_ff       <= acc_in;
      chunk_ff     <= chunk_in;
      prod_ff      <= prod_in;
      q_ff         <= q_in;
      rsp_value_ff <= rsp_value_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_value = rsp_value_ff;
   assign rsp_saturated = rsp_sat_ff;

endmodule

[hdl/int8_dot_product_requant_top.sv]
// int8_dot_product_requant_top: top level of the int8 dot product requantizer
// holds the configuration registers and ties front, queue and back end together
// depends on dpr_pkg, dpr_front, dpr_queue, dpr_back
//
// Streams one activation/weight pair per transaction; the front end removes the
// zero points, multiplies and accumulates, taking a new pair every cycle unless
// a finished total waits on a full queue. On the transaction marked last it adds
// the bias, clears the accumulator and pushes the total into a two-entry queue.
// The back end requantizes one total at a time: a load, one 16-by-31-bit multiply
// step per 16-bit accumulator chunk, a rounding shift, then saturation and relu.
// Dot products at least as long in pairs as a back-end pass run at one pair per
// cycle; shorter ones are paced by the back end once the queue fills. The user
// must write configuration through the csr port while idle; it is not enforced.
module int8_dot_product_requant_top #(
   parameter int ACC_WIDTH = 32
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_valid,
   output logic                                        req_stall,
   input  logic signed [dpr_pkg::ACT_WIDTH-1:0]        req_activation,
   input  logic signed [dpr_pkg::ACT_WIDTH-1:0]        req_weight,
   input  logic signed [dpr_pkg::BIAS_WIDTH-1:0]       req_bias_value,
   input  logic                                        req_last_element,
   output logic                                        rsp_valid,
   input  logic                                        rsp_stall,
   output logic signed [7:0]                           rsp_out_value,
   output logic                                        rsp_saturated,
   input  logic                                        csr_valid,
   output logic                                        csr_ready,
   input  logic [dpr_pkg::CSR_INDEX_WIDTH-1:0]         csr_index,
   input  logic [dpr_pkg::CSR_DATA_WIDTH-1:0]          csr_wdata
);
   import dpr_pkg::*;

   cfg_type              cfg_ff, cfg_in;
   logic                 push_valid;
   logic [ACC_WIDTH-1:0] push_data;
   logic                 queue_full;
   logic                 queue_pop;
   logic [ACC_WIDTH-1:0] queue_data;
   logic                 queue_empty;

   assign csr_ready = 1'b1;

   // configuration register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_ACT_ZP: cfg_in.act_zp  = csr_wdata[7:0];
            CSR_WGT_ZP: cfg_in.wgt_zp  = csr_wdata[7:0];
            CSR_OUT_ZP: cfg_in.out_zp  = csr_wdata[7:0];
            CSR_MULT:   cfg_in.mult    = csr_wdata[MULT_WIDTH-1:0];
            CSR_SHIFT:  cfg_in.shift   = csr_wdata[SHIFT_WIDTH-1:0];
            CSR_RELU:   cfg_in.relu_en = csr_wdata[0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // accumulate front end
   dpr_front #(
      .ACC_WIDTH (ACC_WIDTH)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_activation   (req_activation),
      .req_weight       (req_weight),
      .req_bias_value   (req_bias_value),
      .req_last_element (req_last_element),
      .push_valid       (push_valid),
      .push_data        (push_data),
      .queue_full       (queue_full)
   );

   // queue of finished totals
   dpr_queue #(
      .WIDTH (ACC_WIDTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (queue_full),
      .pop        (queue_pop),
      .pop_data   (queue_data),
      .empty      (queue_empty)
   );

   // requantizing back end
   dpr_back #(
      .ACC_WIDTH (ACC_WIDTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .queue_empty   (queue_empty),
      .queue_data    (queue_data),
      .queue_pop     (queue_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_value (rsp_out_value),
      .rsp_saturated (rsp_saturated)
   );

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// tb: self-checking testbench for int8_dot_product_requant_top
// streams activation/weight pairs, predicts each requantized result in a scoreboard class
// depends on dpr_pkg and the int8_dot_product_requant_top rtl
module tb;
   import dpr_pkg::*;

   localparam int ACC_W         = 32;
   localparam int NUM_PHASES    = 8;
   localparam int PHASE_ITEMS   = 140;
   localparam int SETTLE_CYCLES = 20;
   localparam int HANG_LIMIT    = 5000;
   localparam int MAX_REPORTS   = 50;

   // index past the end of the register list, writes to it are dropped
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_NONE_INDEX = 3'd7;

   typedef struct packed {
      logic signed [7:0] value;
      logic              saturated;
   } dp_result_type;

   // scoreboard: mirrors the accumulator and registers, queues expected results
   class requant_scoreboard;
      cfg_type          cfg;
      logic [ACC_W-1:0] acc_sum;
      dp_result_type    expected_q[$];
      int unsigned      failures;

      function new();
         cfg      = CFG_RESET;
         acc_sum  = '0;
         failures = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_WIDTH-1:0] idx, logic [31:0] data);
         case (csr_index_type'(idx))
            CSR_ACT_ZP: cfg.act_zp  = data[7:0];
            CSR_WGT_ZP: cfg.wgt_zp  = data[7:0];
            CSR_OUT_ZP: cfg.out_zp  = data[7:0];
            CSR_MULT:   cfg.mult    = data[MULT_WIDTH-1:0];
            CSR_SHIFT:  cfg.shift   = data[SHIFT_WIDTH-1:0];
            CSR_RELU:   cfg.relu_en = data[0];
            default: ;
         endcase
      endfunction

      // accumulate one pair, on the last one requantize and queue the result
      function void note_input(logic [7:0] act, logic [7:0] wgt, logic [31:0] bias,
                               logic last);
         logic signed [8:0]   a_off;
         logic signed [8:0]   w_off;
         logic signed [17:0]  prod;
         logic [ACC_W-1:0]    total;
         logic signed [127:0] scaled;
         logic signed [127:0] mult_wide;
         logic signed [127:0] half;
         logic signed [127:0] zp_wide;
         dp_result_type       res;
         a_off = $signed({act[7], act}) - $signed({cfg.act_zp[7], cfg.act_zp});
         w_off = $signed({wgt[7], wgt}) - $signed({cfg.wgt_zp[7], cfg.wgt_zp});
         prod  = a_off * w_off;
         total = acc_sum + {{(ACC_W-18){prod[17]}}, prod};
         if (!last) begin
            acc_sum = total;
            return;
         end
         // bias joins on the last pair only, wrapping like the accumulator
         total   = total + bias;
         acc_sum = '0;
         // exact product, then round half up and floor shift
         scaled    = {{(128-ACC_W){total[ACC_W-1]}}, total};
         mult_wide = {{(128-MULT_WIDTH){1'b0}}, cfg.mult};
         scaled    = scaled * mult_wide;
         if (cfg.shift != 0) begin
            half   = 128'sd1;
            half   = half <<< (cfg.shift - 6'd1);
            scaled = (scaled + half) >>> cfg.shift;
         end
         zp_wide = {{120{cfg.out_zp[7]}}, cfg.out_zp};
         scaled  = scaled + zp_wide;
         res.saturated = 1'b0;
         if (scaled < INT8_MIN) begin
            scaled        = INT8_MIN;
            res.saturated = 1'b1;
         end
         if (scaled > INT8_MAX) begin
            scaled        = INT8_MAX;
            res.saturated = 1'b1;
         end
         // relu floor replaces a clamped value, so it no longer counts as saturated
         if (cfg.relu_en && scaled < zp_wide) begin
            scaled        = zp_wide;
            res.saturated = 1'b0;
         end
         res.value = scaled[7:0];
         expected_q.push_back(res);
      endfunction

      function void check_result(logic signed [7:0] value, logic saturated);
         dp_result_type exp_r;
         if (expected_q.size() == 0) begin
            if (failures < MAX_REPORTS)
               $display("%0t: result with none pending: out_value %0d saturated %0b",
                        $time, value, saturated);
            failures++;
            return;
         end
         exp_r = expected_q.pop_front();
         if (exp_r.value !== value) begin
            if (failures < MAX_REPORTS)
               $display("%0t: out_value expected %0d actual %0d",
                        $time, exp_r.value, value);
            failures++;
         end
         if (exp_r.saturated !== saturated) begin
            if (failures < MAX_REPORTS)
               $display("%0t: saturated expected %0b actual %0b",
                        $time, exp_r.saturated, saturated);
            failures++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                               req_valid        = 1'b0;
   logic                               req_stall;
   logic signed [ACT_WIDTH-1:0]        req_activation   = '0;
   logic signed [ACT_WIDTH-1:0]        req_weight       = '0;
   logic signed [BIAS_WIDTH-1:0]       req_bias_value   = '0;
   logic                               req_last_element = 1'b0;
   logic                               rsp_valid;
   logic                               rsp_stall        = 1'b0;
   logic signed [7:0]                  rsp_out_value;
   logic                               rsp_saturated;
   logic                               csr_valid        = 1'b0;
   logic                               csr_ready;
   logic [CSR_INDEX_WIDTH-1:0]         csr_index        = '0;
   logic [CSR_DATA_WIDTH-1:0]          csr_wdata        = '0;

   requant_scoreboard dp_board = new();

   int sender_idle_pct = 0;
   int recv_stall_pct  = 0;
   int hang_cycles     = 0;

   int8_dot_product_requant_top #(
      .ACC_WIDTH(ACC_W)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_activation  (req_activation),
      .req_weight      (req_weight),
      .req_bias_value  (req_bias_value),
      .req_last_element(req_last_element),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_value   (rsp_out_value),
      .rsp_saturated   (rsp_saturated),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // result side: check each accepted transaction, then pick the next stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         dp_board.check_result(rsp_out_value, rsp_saturated);
      rsp_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
   end

   // watchdog on cycles with no transaction on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         hang_cycles <= 0;
      end else begin
         hang_cycles <= hang_cycles + 1;
      end
      if (hang_cycles >= HANG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // one pair, after a random gap when the sender idles
   task automatic send_item(logic [7:0] act, logic [7:0] wgt, logic [31:0] bias,
                            logic last);
      while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_activation   <= act;
      req_weight       <= wgt;
      req_bias_value   <= bias;
      req_last_element <= last;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      dp_board.note_input(act, wgt, bias, last);
   endtask

   task automatic send_random(logic last);
      logic [31:0] bias;
      if ($urandom_range(3) == 0)
         bias = $urandom;
      else
         bias = $urandom_range(131071) - 65536;
      send_item(8'($urandom), 8'($urandom), bias, last);
   endtask

   // leaves csr_valid high, the caller drops it after its last write
   task automatic write_csr(logic [CSR_INDEX_WIDTH-1:0] idx, logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      dp_board.write_reg(idx, data);
   endtask

   // zero points go out sign extended, the block keeps the low byte
   task automatic write_all(logic signed [7:0] act_zp, logic signed [7:0] wgt_zp,
                            logic signed [7:0] out_zp, logic [30:0] mult,
                            logic [5:0] shift, logic relu);
      write_csr(CSR_ACT_ZP, {{24{act_zp[7]}}, act_zp});
      write_csr(CSR_WGT_ZP, {{24{wgt_zp[7]}}, wgt_zp});
      write_csr(CSR_OUT_ZP, {{24{out_zp[7]}}, out_zp});
      write_csr(CSR_MULT,   {1'b0, mult});
      write_csr(CSR_SHIFT,  {26'd0, shift});
      write_csr(CSR_RELU,   {31'd0, relu});
      csr_valid <= 1'b0;
   endtask

   // wait out every pending result, then the back end's own latency
   task automatic drain();
      req_valid <= 1'b0;
      while (dp_board.pending() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      int count;
      int len;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset configuration, unit scale
      send_item(-128, -128, 0, 1'b1);
      send_item(127, -128, 0, 1'b1);
      send_item(0, 0, 0, 1'b1);
      // bias on pairs that are not last is dropped
      send_item(1, 1, 32'h7fff_ffff, 1'b0);
      send_item(2, 3, 32'hffff_ffff, 1'b0);
      send_item(-5, 7, 32'h0000_1234, 1'b0);
      send_item(4, 4, -10, 1'b1);
      send_item(0, 0, 32'h7fff_ffff, 1'b1);
      send_item(0, 0, 32'h8000_0000, 1'b1);
      // accumulator wraps past the positive limit
      send_item(1, 1, 32'h7fff_ffff, 1'b1);
      send_item(3, 5, -10, 1'b1);
      send_item(-1, 1, 0, 1'b1);
      drain();

      // relu floor, including one that replaces a clamped value
      write_all(0, 0, 10, 31'h4000_0000, 6'd30, 1'b1);
      send_item(0, 0, -50, 1'b1);
      send_item(0, 0, 32'h8000_0000, 1'b1);
      send_item(-128, -128, 0, 1'b1);
      send_item(0, 0, 5, 1'b1);
      drain();

      // zero point extremes, no shift
      write_all(-128, 127, 0, 31'd1, 6'd0, 1'b0);
      send_item(127, -128, 0, 1'b1);
      send_item(-128, 127, 0, 1'b1);
      send_item(-127, 126, 3, 1'b1);
      drain();

      // scale of one half: ties round up
      write_csr(CSR_NONE_INDEX, $urandom);
      write_all(0, 0, 0, 31'h4000_0000, 6'd31, 1'b0);
      send_item(1, 1, 0, 1'b1);
      send_item(-1, 1, 0, 1'b1);
      send_item(3, 1, 0, 1'b1);
      send_item(-3, 1, 0, 1'b1);
      drain();

      // random phases, each with its own settings and one of four idling modes
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0: write_all(-128, 127, 127, 31'h7fff_ffff, 6'd63, 1'b1);
            1: write_all(127, -128, -128, 31'd0, 6'd0, 1'b0);
            2: write_all(0, 0, 0, 31'd1, 6'd0, 1'b0);
            default: write_all(8'($urandom), 8'($urandom), 8'($urandom),
                               31'($urandom_range(31'h7fff_ffff, 31'h4000_0000)),
                               6'($urandom_range(42, 36)), 1'($urandom_range(1)));
         endcase
         case (phase % 4)
            0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin sender_idle_pct = 59; recv_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  recv_stall_pct = 59; end
            default: begin sender_idle_pct = 24; recv_stall_pct = 24; end
         endcase
         count = 0;
         while (count < PHASE_ITEMS) begin
            // mostly short dot products, now and then a long one
            if ($urandom_range(9) == 0)
               len = $urandom_range(40, 9);
            else
               len = $urandom_range(8, 1);
            for (int k = 0; k < len; k++) begin
               send_random(k == len - 1);
               count++;
            end
         end
         drain();
      end

      if (dp_board.failures == 0 && dp_board.pending() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
